>>> rtl/core/aapr_pkg.sv
// ----------------------------------------------------------------------------
// aapr_pkg
// Shared widths, stage indexes, fixed-point constants and types of the
// axis-angle point rotator.
// ----------------------------------------------------------------------------
package aapr_pkg;

    // CORDIC length, capped at the arctangent table size
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int NSTEP        = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

    // Pipeline stage indexes
    localparam int ST_TRIG = NSTEP + 1;
    localparam int ST_MUL  = NSTEP + 2;
    localparam int ST_SUM  = NSTEP + 3;
    localparam int NUM_ST  = NSTEP + 4;

    // Field and datapath widths
    localparam int POS_W     = 32;
    localparam int ANG_W     = 20;
    localparam int AXIS_W    = 18;
    localparam int CFG_IDX_W = 2;
    localparam int ZR_W      = 36;   // angle during range reduction, Q30
    localparam int ZW        = 33;   // CORDIC residual angle, Q30
    localparam int XW        = 33;   // CORDIC x/y, Q30
    localparam int CS_W      = XW - 6;   // sin, cos, 1-cos in Q24
    localparam int PR_W      = AXIS_W + POS_W;   // axis by point product
    localparam int SM_W      = PR_W + 2;         // cross/dot sums
    localparam int CR_W      = SM_W - 16;        // cross and dot in Q16
    localparam int KP_W      = AXIS_W + CR_W;    // axis by dot product
    localparam int KD_W      = KP_W - 16;        // k*(k.v) in Q16
    localparam int PV_W      = POS_W + CS_W;
    localparam int PC_W      = CR_W + CS_W;
    localparam int PK_W      = KD_W + CS_W;
    localparam int AC_W      = PK_W + 3;         // Q40 accumulator
    localparam int RS_W      = AC_W - 24;        // result before saturation

    localparam logic signed [ZR_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ZR_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [ZR_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [XW-1:0]   GAIN_Q30    = 33'sd652032874;
    localparam logic signed [CS_W-1:0] ONE_Q24     = 27'sd16777216;
    localparam logic signed [POS_W-1:0] POS_MAX    = 32'sh7fffffff;
    localparam logic signed [POS_W-1:0] POS_MIN    = 32'sh80000000;

    // Truncated atan(2^-i) in Q30
    localparam logic signed [ZW-1:0] ATAN_Q30 [TABLE_LEN] = '{
        33'sd843314856, 33'sd497837829, 33'sd263043836, 33'sd133525158,
        33'sd67021686,  33'sd33543515,  33'sd16775850,  33'sd8388437,
        33'sd4194282,   33'sd2097149,   33'sd1048575,   33'sd524287,
        33'sd262143,    33'sd131071,    33'sd65535,     33'sd32767,
        33'sd16383,     33'sd8191,      33'sd4095,      33'sd2047,
        33'sd1023,      33'sd511,       33'sd255,       33'sd127
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AXIS_X = 2'd0,
        REG_AXIS_Y = 2'd1,
        REG_AXIS_Z = 2'd2
    } cfg_reg_t;

    localparam logic signed [AXIS_W-1:0] AXIS_X_RST = 18'sd0;
    localparam logic signed [AXIS_W-1:0] AXIS_Y_RST = 18'sd0;
    localparam logic signed [AXIS_W-1:0] AXIS_Z_RST = 18'sd65536;

    // Per-stage load enables, one bit above the last stage for the sink ready
    typedef logic [NUM_ST:0] stage_en_t;

    typedef struct packed {
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
    } axis_t;

endpackage

>>> rtl/core/aapr_point_if.sv
// ----------------------------------------------------------------------------
// aapr_point_if
// Point channel: position and rotation angle with valid/ready.
// ----------------------------------------------------------------------------
interface aapr_point_if;
    import aapr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [ANG_W-1:0]  angle;

    modport source (output valid, pos_x, pos_y, pos_z, angle, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, angle, output ready);
endinterface

>>> rtl/core/aapr_result_if.sv
// ----------------------------------------------------------------------------
// aapr_result_if
// Result channel: rotated point and saturation flag with valid/ready.
// ----------------------------------------------------------------------------
interface aapr_result_if;
    import aapr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  rot_x;
    logic signed [POS_W-1:0]  rot_y;
    logic signed [POS_W-1:0]  rot_z;
    logic                     clipped;

    modport source (output valid, rot_x, rot_y, rot_z, clipped, input ready);
    modport sink   (input valid, rot_x, rot_y, rot_z, clipped, output ready);
endinterface

>>> rtl/core/aapr_cfg_if.sv
// ----------------------------------------------------------------------------
// aapr_cfg_if
// Configuration write channel: register index and data with valid/ready.
// ----------------------------------------------------------------------------
interface aapr_cfg_if;
    import aapr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_W-1:0]     index;
    logic [AXIS_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/aapr_cordic.sv
// ----------------------------------------------------------------------------
// aapr_cordic
// Angle range reduction, pipelined rotation-mode CORDIC, and rounding of
// sine, cosine and one minus cosine to Q24.
// ----------------------------------------------------------------------------
module aapr_cordic (
    input  logic                               clk,
    input  aapr_pkg::stage_en_t                en,
    input  logic signed [aapr_pkg::ANG_W-1:0]  angle,
    output logic signed [aapr_pkg::CS_W-1:0]   cos_q24,
    output logic signed [aapr_pkg::CS_W-1:0]   sin_q24,
    output logic signed [aapr_pkg::CS_W-1:0]   omc_q24
);
    import aapr_pkg::*;

    logic signed [ZR_W-1:0] z_ext;
    logic signed [ZR_W-1:0] z_wrap;
    logic signed [ZR_W-1:0] z_fold;
    logic                   neg_next;

    logic signed [ZW-1:0]   z_reg   [0:NSTEP];
    logic                   neg_reg [0:NSTEP];
    logic signed [XW-1:0]   x_reg   [1:NSTEP];
    logic signed [XW-1:0]   y_reg   [1:NSTEP];

    logic signed [XW:0]     x_sgn;
    logic signed [XW:0]     x_rnd;
    logic signed [XW:0]     y_rnd;
    logic signed [CS_W-1:0] cos_reg;
    logic signed [CS_W-1:0] sin_reg;
    logic signed [CS_W-1:0] omc_reg;

    // Wrap to [-pi, pi], then fold to [-pi/2, pi/2] with cosine sign flip
    always_comb
    begin
        z_ext = {{(ZR_W-ANG_W-14){angle[ANG_W-1]}}, angle, 14'b0};
        if (z_ext > PI_Q30)
        begin
            z_wrap = z_ext - TWO_PI_Q30;
        end
        else if (z_ext < -PI_Q30)
        begin
            z_wrap = z_ext + TWO_PI_Q30;
        end
        else
        begin
            z_wrap = z_ext;
        end
        neg_next = 1'b0;
        z_fold   = z_wrap;
        if (z_wrap > HALF_PI_Q30)
        begin
            z_fold   = PI_Q30 - z_wrap;
            neg_next = 1'b1;
        end
        else if (z_wrap < -HALF_PI_Q30)
        begin
            z_fold   = -PI_Q30 - z_wrap;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            z_reg[0]   <= z_fold[ZW-1:0];
            neg_reg[0] <= neg_next;
        end
    end

    for (genvar i = 0; i < NSTEP; i++)
    begin : g_step
        logic signed [XW-1:0] x_in;
        logic signed [XW-1:0] y_in;
        logic signed [XW-1:0] x_next;
        logic signed [XW-1:0] y_next;
        logic signed [ZW-1:0] z_next;

        if (i == 0)
        begin : g_first
            assign x_in = GAIN_Q30;
            assign y_in = '0;
        end
        else
        begin : g_rest
            assign x_in = x_reg[i];
            assign y_in = y_reg[i];
        end

        // Rotate toward zero residual angle
        always_comb
        begin
            if (!z_reg[i][ZW-1])
            begin
                x_next = x_in - (y_in >>> i);
                y_next = y_in + (x_in >>> i);
                z_next = z_reg[i] - ATAN_Q30[i];
            end
            else
            begin
                x_next = x_in + (y_in >>> i);
                y_next = y_in - (x_in >>> i);
                z_next = z_reg[i] + ATAN_Q30[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[i+1])
            begin
                x_reg[i+1]   <= x_next;
                y_reg[i+1]   <= y_next;
                z_reg[i+1]   <= z_next;
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    always_comb
    begin
        x_sgn = neg_reg[NSTEP] ? -{x_reg[NSTEP][XW-1], x_reg[NSTEP]}
                               :  {x_reg[NSTEP][XW-1], x_reg[NSTEP]};
        x_rnd = x_sgn + (XW+1)'(32);
        y_rnd = {y_reg[NSTEP][XW-1], y_reg[NSTEP]} + (XW+1)'(32);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_TRIG])
        begin
            cos_reg <= x_rnd[XW-1:6];
            sin_reg <= y_rnd[XW-1:6];
            omc_reg <= ONE_Q24 - x_rnd[XW-1:6];
        end
    end

    assign cos_q24 = cos_reg;
    assign sin_q24 = sin_reg;
    assign omc_q24 = omc_reg;

endmodule

>>> rtl/core/aapr_vec.sv
// ----------------------------------------------------------------------------
// aapr_vec
// Cross product k x v, dot product k.v and k*(k.v), then delay of the point,
// cross product and projection to meet the CORDIC output.
// ----------------------------------------------------------------------------
module aapr_vec (
    input  logic                               clk,
    input  aapr_pkg::stage_en_t                en,
    input  aapr_pkg::axis_t                    axis,
    input  logic signed [aapr_pkg::POS_W-1:0]  pos_x,
    input  logic signed [aapr_pkg::POS_W-1:0]  pos_y,
    input  logic signed [aapr_pkg::POS_W-1:0]  pos_z,
    output logic signed [aapr_pkg::POS_W-1:0]  v_out  [3],
    output logic signed [aapr_pkg::CR_W-1:0]   cr_out [3],
    output logic signed [aapr_pkg::KD_W-1:0]   kd_out [3]
);
    import aapr_pkg::*;

    // Products: 0..5 feed the cross product, 6..8 the dot product
    logic signed [PR_W-1:0]  prod_reg [9];
    logic signed [SM_W-1:0]  cr_sum   [3];
    logic signed [SM_W-1:0]  dot_sum;
    logic signed [CR_W-1:0]  dot_reg;
    logic signed [KP_W-1:0]  kp_reg   [3];
    logic signed [KP_W-1:0]  kp_rnd   [3];
    logic signed [KD_W-1:0]  kd_next  [3];
    logic signed [AXIS_W-1:0] k [3];

    logic signed [POS_W-1:0] v_d  [0:ST_TRIG][3];
    logic signed [CR_W-1:0]  c_d  [1:ST_TRIG][3];
    logic signed [KD_W-1:0]  kd_d [3:ST_TRIG][3];

    assign k[0] = axis.x;
    assign k[1] = axis.y;
    assign k[2] = axis.z;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prod_reg[0] <= axis.y * pos_z;
            prod_reg[1] <= axis.z * pos_y;
            prod_reg[2] <= axis.z * pos_x;
            prod_reg[3] <= axis.x * pos_z;
            prod_reg[4] <= axis.x * pos_y;
            prod_reg[5] <= axis.y * pos_x;
            prod_reg[6] <= axis.x * pos_x;
            prod_reg[7] <= axis.y * pos_y;
            prod_reg[8] <= axis.z * pos_z;
            v_d[0][0]   <= pos_x;
            v_d[0][1]   <= pos_y;
            v_d[0][2]   <= pos_z;
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            cr_sum[j] = prod_reg[2*j] - prod_reg[2*j+1] + SM_W'(32768);
        end
        dot_sum = prod_reg[6] + prod_reg[7] + prod_reg[8] + SM_W'(32768);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int j = 0; j < 3; j++)
            begin
                c_d[1][j] <= cr_sum[j][SM_W-1:16];
            end
            dot_reg <= dot_sum[SM_W-1:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int j = 0; j < 3; j++)
            begin
                kp_reg[j] <= k[j] * dot_reg;
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            kp_rnd[j]  = kp_reg[j] + KP_W'(32768);
            kd_next[j] = kp_rnd[j][KP_W-1:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            kd_d[3] <= kd_next;
        end
    end

    // Delay lines up to the trig stage
    for (genvar s = 1; s <= ST_TRIG; s++)
    begin : g_vdly
        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                v_d[s] <= v_d[s-1];
            end
        end
    end

    for (genvar s = 2; s <= ST_TRIG; s++)
    begin : g_cdly
        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                c_d[s] <= c_d[s-1];
            end
        end
    end

    for (genvar s = 4; s <= ST_TRIG; s++)
    begin : g_kdly
        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                kd_d[s] <= kd_d[s-1];
            end
        end
    end

    assign v_out  = v_d[ST_TRIG];
    assign cr_out = c_d[ST_TRIG];
    assign kd_out = kd_d[ST_TRIG];

endmodule

>>> rtl/core/aapr_combine.sv
// ----------------------------------------------------------------------------
// aapr_combine
// Rodrigues sum v*cos + (k x v)*sin + k*(k.v)*(1-cos), rounding to Q16.16
// and saturation; holds the output register.
// ----------------------------------------------------------------------------
module aapr_combine (
    input  logic                               clk,
    input  aapr_pkg::stage_en_t                en,
    input  logic signed [aapr_pkg::POS_W-1:0]  v_in   [3],
    input  logic signed [aapr_pkg::CR_W-1:0]   cr_in  [3],
    input  logic signed [aapr_pkg::KD_W-1:0]   kd_in  [3],
    input  logic signed [aapr_pkg::CS_W-1:0]   cos_q24,
    input  logic signed [aapr_pkg::CS_W-1:0]   sin_q24,
    input  logic signed [aapr_pkg::CS_W-1:0]   omc_q24,
    output logic signed [aapr_pkg::POS_W-1:0]  rot    [3],
    output logic                               clipped
);
    import aapr_pkg::*;

    logic signed [PV_W-1:0]  pv_reg [3];
    logic signed [PC_W-1:0]  pc_reg [3];
    logic signed [PK_W-1:0]  pk_reg [3];
    logic signed [AC_W-1:0]  acc    [3];
    logic signed [RS_W-1:0]  res    [3];
    logic signed [POS_W-1:0] rot_next [3];
    logic                    clip_next;
    logic signed [POS_W-1:0] rot_reg  [3];
    logic                    clip_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_MUL])
        begin
            for (int j = 0; j < 3; j++)
            begin
                pv_reg[j] <= v_in[j]  * cos_q24;
                pc_reg[j] <= cr_in[j] * sin_q24;
                pk_reg[j] <= kd_in[j] * omc_q24;
            end
        end
    end

    always_comb
    begin
        clip_next = 1'b0;
        for (int j = 0; j < 3; j++)
        begin
            // Keep the rounding constant signed so the products sign-extend
            acc[j] = pv_reg[j] + pc_reg[j] + pk_reg[j] + AC_W'(32'sd8388608);
            res[j] = acc[j][AC_W-1:24];
            if (res[j] > RS_W'(POS_MAX))
            begin
                rot_next[j] = POS_MAX;
                clip_next   = 1'b1;
            end
            else if (res[j] < RS_W'(POS_MIN))
            begin
                rot_next[j] = POS_MIN;
                clip_next   = 1'b1;
            end
            else
            begin
                rot_next[j] = res[j][POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SUM])
        begin
            rot_reg  <= rot_next;
            clip_reg <= clip_next;
        end
    end

    assign rot     = rot_reg;
    assign clipped = clip_reg;

endmodule

>>> rtl/core/axis_angle_point_rotator.sv
// ----------------------------------------------------------------------------
// axis_angle_point_rotator
// Rotates a Q16.16 point about the configured unit axis by its own angle.
// ----------------------------------------------------------------------------
// Each point transfer carries its own angle; the block returns one result per
// point, in order. The pipeline is CORDIC_STEPS + 4 stages deep (20 at the
// default of 16 CORDIC iterations), one stage per CORDIC iteration plus range
// reduction, sin/cos rounding, the product stage and the final sum, and it takes
// a new point every cycle unless the output stalls. Each stage holds its item
// until the next one frees, so bubbles close up and a point is refused only
// when every stage is full. Write the axis, already normalized, in Q2.16
// through the configuration channel only while no point is in flight.
// ----------------------------------------------------------------------------
module axis_angle_point_rotator (
    input  logic            clk,
    input  logic            rst_n,
    aapr_point_if.sink      pnt,
    aapr_result_if.source   res,
    aapr_cfg_if.sink        cfg
);
    import aapr_pkg::*;

    axis_t                  axis_reg;
    axis_t                  axis_next;
    logic [NUM_ST-1:0]      vld_reg;
    logic [NUM_ST-1:0]      vld_next;
    stage_en_t              en;

    logic signed [POS_W-1:0] v_dly  [3];
    logic signed [CR_W-1:0]  cr_dly [3];
    logic signed [KD_W-1:0]  kd_dly [3];
    logic signed [CS_W-1:0]  cos_q24;
    logic signed [CS_W-1:0]  sin_q24;
    logic signed [CS_W-1:0]  omc_q24;
    logic signed [POS_W-1:0] rot [3];
    logic                    clipped;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        axis_next = axis_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_AXIS_X: axis_next.x = cfg.data;
                REG_AXIS_Y: axis_next.y = cfg.data;
                REG_AXIS_Z: axis_next.z = cfg.data;
                default:    axis_next   = axis_reg;
            endcase
        end
    end

    // A stage loads when it is empty or its successor loads
    always_comb
    begin
        en[NUM_ST] = res.ready;
        for (int i = NUM_ST - 1; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        for (int i = 0; i < NUM_ST; i++)
        begin
            if (!en[i])
            begin
                vld_next[i] = vld_reg[i];
            end
            else if (i == 0)
            begin
                vld_next[i] = pnt.valid;
            end
            else
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg <= '{x: AXIS_X_RST, y: AXIS_Y_RST, z: AXIS_Z_RST};
            vld_reg  <= '0;
        end
        else
        begin
            axis_reg <= axis_next;
            vld_reg  <= vld_next;
        end
    end

    assign pnt.ready = en[0];

    aapr_cordic u_cordic (
        .clk     (clk),
        .en      (en),
        .angle   (pnt.angle),
        .cos_q24 (cos_q24),
        .sin_q24 (sin_q24),
        .omc_q24 (omc_q24)
    );

    aapr_vec u_vec (
        .clk    (clk),
        .en     (en),
        .axis   (axis_reg),
        .pos_x  (pnt.pos_x),
        .pos_y  (pnt.pos_y),
        .pos_z  (pnt.pos_z),
        .v_out  (v_dly),
        .cr_out (cr_dly),
        .kd_out (kd_dly)
    );

    aapr_combine u_combine (
        .clk     (clk),
        .en      (en),
        .v_in    (v_dly),
        .cr_in   (cr_dly),
        .kd_in   (kd_dly),
        .cos_q24 (cos_q24),
        .sin_q24 (sin_q24),
        .omc_q24 (omc_q24),
        .rot     (rot),
        .clipped (clipped)
    );

    assign res.valid   = vld_reg[NUM_ST-1];
    assign res.rot_x   = rot[0];
    assign res.rot_y   = rot[1];
    assign res.rot_z   = rot[2];
    assign res.clipped = clipped;

    // Any empty stage must let a new point in
    a_ready_on_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !(&vld_reg) |-> pnt.ready)
        else $error("point channel stalled with an empty stage");

    // A flagged result has at least one component at a limit
    a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.clipped) |->
            (res.rot_x == POS_MAX || res.rot_x == POS_MIN ||
             res.rot_y == POS_MAX || res.rot_y == POS_MIN ||
             res.rot_z == POS_MAX || res.rot_z == POS_MIN))
        else $error("clipped set without a saturated component");

    // The stage before the output holds its item while the output is stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NUM_ST-2] && res.valid && !res.ready) |=> vld_reg[NUM_ST-2])
        else $error("item dropped behind a stalled output");

endmodule
